/* src/prm_pkg.sv */
// Shared types and constants of the pulse rate meter.
package prm_pkg;

	// Rate scale factors: 60e6 * 256 and 1e6 * 256, both below 2^34.
	localparam logic [33:0] SCALE_MIN = 34'd15360000000;
	localparam logic [33:0] SCALE_SEC = 34'd256000000;

	localparam logic [39:0] SAT40 = {40{1'b1}};
	localparam logic [47:0] SAT48 = {48{1'b1}};
	localparam logic [31:0] SAT32 = {32{1'b1}};

	// Divider passes: full scaled product, or the total left-aligned.
	localparam logic [6:0] DIV_RATE_STEPS = 7'd66;
	localparam logic [6:0] DIV_REVS_STEPS = 7'd48;

	// Register indexes.
	localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
	localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_PULSES_REV   = 3'd2;
	localparam logic [2:0] REG_EN_PER_SEC   = 3'd3;
	localparam logic [2:0] REG_EN_TOTAL     = 3'd4;
	localparam logic [2:0] REG_EN_REVS      = 3'd5;

	// Commands and rate kinds.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_RATE = 2'd1;
	localparam logic [1:0] KIND_IDLE = 2'd2;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_CHECK    = 9'b000000010,
		ST_TALLY    = 9'b000000100,
		ST_MUL_LO   = 9'b000001000,
		ST_MUL_HI   = 9'b000010000,
		ST_DIV      = 9'b000100000,
		ST_DIV_END  = 9'b001000000,
		ST_REV_LOAD = 9'b010000000,
		ST_FINISH   = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		JOB_PM = 2'd0,
		JOB_PS = 2'd1,
		JOB_RV = 2'd2
	} job_t;

endpackage

/* src/pulse_rate_meter_unit.sv */
// Pulse rate meter: sample accumulation, throttled publish, shared divider.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    command, count_delta, time_us
//  out      out  out_valid/out_ready  rate_kind .. revolutions
//  cfg      in   APB psel/penable     paddr[4:0], pwdata, prdata
//
// A count sample is taken in ST_IDLE; a throttled tick returns from ST_CHECK
// and gives no beat. A passed tick runs ST_CHECK, ST_TALLY, ST_MUL_LO to
// ST_DIV_END for each rate that applies, ST_REV_LOAD, the revolutions pass
// where it applies, ST_FINISH: one restoring divider, a quotient bit a cycle.
// The block is not ready from a tick's acceptance until its beat is loaded
// into the output register; a held output beat stalls only that last load.
// Reset clears config, state and out_valid at once; data regs are not reset.
module pulse_rate_meter_unit
	import prm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [15:0] count_delta,
	input  logic [47:0]        time_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         rate_kind,
	output logic [39:0]        per_minute,
	output logic [39:0]        per_second,
	output logic               total_valid,
	output logic [47:0]        total_pulses,
	output logic               revs_valid,
	output logic [47:0]        revolutions
);

	// configuration
	logic [31:0] min_interval_q;
	logic [31:0] idle_timeout_q;
	logic [15:0] ppr_q;
	logic        en_ps_q;
	logic        en_total_q;
	logic        en_revs_q;

	// block state
	logic [31:0] pending_q;
	logic [47:0] last_pulse_q;
	logic [47:0] last_emit_q;
	logic        has_emitted_q;
	logic        idle_armed_q;
	logic [47:0] total_q;
	logic [47:0] last_revs_q;

	// work registers
	state_t      state_q;
	job_t        job_q;
	logic [47:0] now_q;
	logic [31:0] pulses_q;
	logic [47:0] since_q;
	logic [65:0] dvd_q;
	logic [47:0] rem_q;
	logic [6:0]  cnt_q;
	logic [1:0]  kind_q;
	logic [39:0] pm_q;
	logic [39:0] ps_q;
	logic        tvalid_q;
	logic [47:0] tout_q;
	logic        rvalid_q;
	logic [47:0] rout_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  rate_kind_q;
	logic [39:0] per_minute_q;
	logic [39:0] per_second_q;
	logic        total_valid_q;
	logic [47:0] total_pulses_q;
	logic        revs_valid_q;
	logic [47:0] revolutions_q;

	logic        cfg_write;
	logic        in_beat;
	logic        delta_pos;
	logic [32:0] pending_sum;
	logic [47:0] since;
	logic        pass;
	logic [48:0] total_sum;
	logic [47:0] total_next;
	logic [47:0] idle_gap;
	logic        idle_hit;
	logic [31:0] klo;
	logic [1:0]  khi;
	logic [63:0] prod_lo;
	logic [33:0] prod_hi;
	logic [47:0] divisor;
	logic [48:0] rem_sh;
	logic [49:0] diff;
	logic        ge;
	logic [39:0] quot_sat;
	logic        out_load;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[4:2])
			REG_MIN_INTERVAL: prdata = min_interval_q;
			REG_IDLE_TIMEOUT: prdata = idle_timeout_q;
			REG_PULSES_REV:   prdata = {16'b0, ppr_q};
			REG_EN_PER_SEC:   prdata = {31'b0, en_ps_q};
			REG_EN_TOTAL:     prdata = {31'b0, en_total_q};
			REG_EN_REVS:      prdata = {31'b0, en_revs_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= '0;
			idle_timeout_q <= '0;
			ppr_q          <= '0;
			en_ps_q        <= 1'b0;
			en_total_q     <= 1'b0;
			en_revs_q      <= 1'b0;
		end else if (cfg_write) begin
			unique case (paddr[4:2])
				REG_MIN_INTERVAL: min_interval_q <= pwdata;
				REG_IDLE_TIMEOUT: idle_timeout_q <= pwdata;
				REG_PULSES_REV:   ppr_q          <= pwdata[15:0];
				REG_EN_PER_SEC:   en_ps_q        <= pwdata[0];
				REG_EN_TOTAL:     en_total_q     <= pwdata[0];
				REG_EN_REVS:      en_revs_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign in_beat     = in_valid & in_ready;
	assign delta_pos   = ~count_delta[15] & (count_delta != 16'sd0);
	assign pending_sum = {1'b0, pending_q} + {17'b0, count_delta[15:0]};

	assign since = has_emitted_q ? (now_q - last_emit_q) : {16'b0, min_interval_q};
	assign pass  = (since >= {16'b0, min_interval_q});

	assign total_sum  = {1'b0, total_q} + {17'b0, pulses_q};
	assign total_next = total_sum[48] ? SAT48 : total_sum[47:0];
	assign idle_gap   = now_q - last_pulse_q;
	assign idle_hit   = (idle_timeout_q != 32'd0) & idle_armed_q & (last_pulse_q != 48'd0)
		& (idle_gap >= {16'b0, idle_timeout_q});

	assign klo     = (job_q == JOB_PS) ? SCALE_SEC[31:0] : SCALE_MIN[31:0];
	assign khi     = (job_q == JOB_PS) ? SCALE_SEC[33:32] : SCALE_MIN[33:32];
	assign prod_lo = pulses_q * klo;
	assign prod_hi = pulses_q * khi;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign divisor  = (job_q == JOB_RV) ? {32'b0, ppr_q} : since_q;
	assign rem_sh   = {rem_q, dvd_q[65]};
	assign diff     = {1'b0, rem_sh} - {2'b0, divisor};
	assign ge       = ~diff[49];
	assign quot_sat = (dvd_q[65:40] != 26'd0) ? SAT40 : dvd_q[39:0];

	assign out_load = (state_q == ST_FINISH) & (~out_valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			job_q         <= JOB_PM;
			pending_q     <= '0;
			last_pulse_q  <= '0;
			last_emit_q   <= '0;
			has_emitted_q <= 1'b0;
			idle_armed_q  <= 1'b0;
			total_q       <= '0;
			last_revs_q   <= '0;
			cnt_q         <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						now_q <= time_us;
						if (command == CMD_TICK) begin
							state_q <= ST_CHECK;
						end else if (delta_pos) begin
							pending_q    <= pending_sum[32] ? SAT32 : pending_sum[31:0];
							last_pulse_q <= time_us;
							idle_armed_q <= 1'b1;
						end
					end
				end
				ST_CHECK: begin
					if (pass) begin
						pulses_q      <= pending_q;
						pending_q     <= '0;
						since_q       <= since;
						last_emit_q   <= now_q;
						has_emitted_q <= 1'b1;
						state_q       <= ST_TALLY;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_TALLY: begin
					pm_q     <= '0;
					ps_q     <= '0;
					rvalid_q <= 1'b0;
					rout_q   <= '0;
					tvalid_q <= 1'b0;
					tout_q   <= '0;
					kind_q   <= KIND_NONE;
					job_q    <= JOB_PM;
					state_q  <= ST_REV_LOAD;
					if (pulses_q != 32'd0) begin
						total_q <= total_next;
						if (en_total_q) begin
							tvalid_q <= 1'b1;
							tout_q   <= total_next;
						end
						if (since_q != 48'd0) begin
							kind_q       <= KIND_RATE;
							idle_armed_q <= 1'b1;
							state_q      <= ST_MUL_LO;
						end
					end else if (idle_hit) begin
						kind_q       <= KIND_IDLE;
						idle_armed_q <= 1'b0;
					end
				end
				ST_MUL_LO: begin
					dvd_q   <= {2'b00, prod_lo};
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					dvd_q   <= dvd_q + {prod_hi, 32'b0};
					rem_q   <= '0;
					cnt_q   <= DIV_RATE_STEPS;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? diff[47:0] : rem_sh[47:0];
					dvd_q <= {dvd_q[64:0], ge};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= ST_DIV_END;
					end
				end
				ST_DIV_END: begin
					case (job_q)
						JOB_PM: begin
							pm_q <= quot_sat;
							if (en_ps_q) begin
								job_q   <= JOB_PS;
								state_q <= ST_MUL_LO;
							end else begin
								state_q <= ST_REV_LOAD;
							end
						end
						JOB_PS: begin
							ps_q    <= quot_sat;
							state_q <= ST_REV_LOAD;
						end
						default: begin
							if (dvd_q[47:0] != last_revs_q) begin
								last_revs_q <= dvd_q[47:0];
								rvalid_q    <= 1'b1;
								rout_q      <= dvd_q[47:0];
							end
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_REV_LOAD: begin
					if (en_revs_q && ppr_q != 16'd0) begin
						job_q   <= JOB_RV;
						dvd_q   <= {total_q, 18'b0};
						rem_q   <= '0;
						cnt_q   <= DIV_REVS_STEPS;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rate_kind_q    <= kind_q;
			per_minute_q   <= pm_q;
			per_second_q   <= ps_q;
			total_valid_q  <= tvalid_q;
			total_pulses_q <= tout_q;
			revs_valid_q   <= rvalid_q;
			revolutions_q  <= rout_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign rate_kind    = rate_kind_q;
	assign per_minute   = per_minute_q;
	assign per_second   = per_second_q;
	assign total_valid  = total_valid_q;
	assign total_pulses = total_pulses_q;
	assign revs_valid   = revs_valid_q;
	assign revolutions  = revolutions_q;

endmodule

/* src/prm_checker.sv */
// Port-level checks of the pulse rate meter, bound to the top level.
module prm_checker
	import prm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        command,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  rate_kind,
	input logic [39:0] per_minute,
	input logic [39:0] per_second,
	input logic        total_valid,
	input logic [47:0] total_pulses,
	input logic        revs_valid,
	input logic [47:0] revolutions
);

	// a tick beat always occupies the sequencer: ready is low right after it
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_TICK |=> !in_ready)
		else $error("ready high right after a tick beat");

	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rate_kind != KIND_RATE |-> per_minute == 40'd0 && per_second == 40'd0)
		else $error("rate fields nonzero without a measured rate");

	a_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !total_valid |-> total_pulses == 48'd0)
		else $error("total shown while not valid");

	a_revs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !revs_valid |-> revolutions == 48'd0)
		else $error("revolutions shown while not valid");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(per_minute) && $stable(revolutions))
		else $error("output beat dropped or changed while stalled");

endmodule

bind pulse_rate_meter_unit prm_checker u_prm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.command      (command),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.rate_kind    (rate_kind),
	.per_minute   (per_minute),
	.per_second   (per_second),
	.total_valid  (total_valid),
	.total_pulses (total_pulses),
	.revs_valid   (revs_valid),
	.revolutions  (revolutions)
);
